/* design/rolling_volatility_regime_classifier_assert.svh */
// Assertion macros for the rolling volatility regime classifier.
// Depends on nothing; included by the top level.
`ifndef ROLLING_VOLATILITY_REGIME_CLASSIFIER_ASSERT_SVH
`define ROLLING_VOLATILITY_REGIME_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define RVR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RVR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RVR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/rvr_pkg.sv */
// Package for the rolling volatility regime classifier: types and constants.
// Depends on nothing.
`default_nettype none
package rvr_pkg;
    localparam int Window = 50;
    localparam int SlotW  = $clog2(Window);
    localparam int CntW   = $clog2(Window + 1);
    localparam logic [63:0] RateScale     = 64'd65536000000000;
    localparam logic [47:0] ZeroInterval  = 48'd1000000;
    localparam logic [47:0] IntervalMax   = 48'hFFFF_FFFF_FFFF;
    // ceil(2^30 / 100): exact quotient by 100 for any 23-bit dividend
    localparam logic [23:0] Div100Recip   = 24'd10737419;

    typedef struct packed {
        logic [31:0] tick_price;
        logic [63:0] time_ns;
    } t_in;

    typedef struct packed {
        logic        primed;
        logic [1:0]  regime;
        logic [31:0] volatility;
        logic [47:0] intensity;
        logic [31:0] volatility_baseline;
        logic [47:0] intensity_baseline;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_RET, S_RD, S_ACC, S_MEAN, S_MSQ, S_VAR, S_SQRT,
        S_RATE, S_EMAV, S_EMAR, S_OUT
    } t_state;

    // divider request/response between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [127:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [127:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

/* design/rvr_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rvr_pkg.
`default_nettype none
module rvr_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rvr_pkg::t_div_req i_req,
    output rvr_pkg::t_div_rsp     o_rsp
);
    import rvr_pkg::*;
    logic [127:0] r_q, n_q;
    logic [64:0]  r_rem, n_rem;
    logic [63:0]  r_den;
    logic [7:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy, r_done, n_done;
    logic [64:0]  w_sh;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_rem[63:0], r_q[127]};
        if (i_req.start) begin
            n_q = i_req.num; n_rem = '0; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = {r_q[126:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[126:0], 1'b0};
            end
            n_cnt = r_cnt + 8'd1;
            if (r_cnt == 8'd127) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
endmodule
`default_nettype wire

/* design/rvr_sqrt.sv */
// Bit-pair integer square root, one result bit per cycle.
// Depends on rvr_pkg.
`default_nettype none
module rvr_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);
    import rvr_pkg::*;
    logic [63:0] r_v, n_v;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [33:0] w_trial, w_cur;

    always_comb begin
        n_v = r_v; n_rem = r_rem; n_root = r_root; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_cur   = {r_rem[31:0], r_v[63:62]};
        w_trial = {r_root, 2'b01};
        if (i_start) begin
            n_v = i_val; n_rem = '0; n_root = '0; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_v = {r_v[61:0], 2'b00};
            if (w_cur >= w_trial) begin
                n_rem  = w_cur - w_trial;
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = w_cur;
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_v <= n_v; r_rem <= n_rem; r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

/* design/rvr_ring.sv */
// Window ring memory: return and interval per slot, one address shared by the
// write and the read, registered read data. Depends on rvr_pkg.
`default_nettype none
module rvr_ring (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [rvr_pkg::SlotW-1:0] i_addr,
    input  wire logic [79:0]               i_wdata,
    output logic [79:0]                    o_rdata
);
    import rvr_pkg::*;
    logic [79:0] r_mem [Window];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* design/rolling_volatility_regime_classifier.sv */
// Each accepted sample runs four divider passes, a square root, a ring read
// and write, and two divide-by-100 steps, each skipped when it seeds its
// baseline; a priming sample goes straight to the result.
// Throughput: one sample in flight, the next taken the cycle after the result
// leaves.
// Reset: synchronous, active low; clears sums, counters, baselines, not the ring.
`default_nettype none
`include "rolling_volatility_regime_classifier_assert.svh"
module rolling_volatility_regime_classifier (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rvr_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rvr_pkg::t_out      o_data
);
    import rvr_pkg::*;

    t_state r_state, n_state;
    t_in    r_in;
    logic [31:0] r_last_price;
    logic [63:0] r_last_time;
    logic [CntW-1:0]  r_fill;
    logic [SlotW-1:0] r_slot;
    logic signed [37:0] r_rsum;
    logic [63:0] r_ssum;
    logic [53:0] r_isum;
    logic [31:0] r_vol, r_vbase;
    logic [47:0] r_rate, r_rbase;
    logic signed [32:0] r_ret;     // new return
    logic [47:0] r_iv;             // new interval
    logic [63:0] r_mm;             // rounded |mean|, then scratch
    logic [63:0] r_var;
    logic        r_sub;            // window full: retire the oldest entry

    // sub-steps of the div-using states
    logic r_wait, n_wait;

    // divide by 100: four 16-bit chunks, high chunk first
    logic [63:0] r_c_x, r_c_q;
    logic [6:0]  r_c_rem;
    logic [1:0]  r_c_cnt;
    logic [22:0] w_c_v, w_c_rem;
    logic [46:0] w_c_prod;
    logic [15:0] w_c_qd;
    logic [63:0] w_c_q;

    // output register
    t_out r_out;
    logic r_ovalid;

    // ring
    logic        w_we;
    logic [79:0] w_rdata;
    rvr_ring u_ring (
        .i_clk(i_clk), .i_we(w_we), .i_addr(r_slot),
        .i_wdata({r_ret[31:0], r_iv}), .o_rdata(w_rdata)
    );

    // divider
    t_div_req w_req;
    t_div_rsp w_rsp;
    rvr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // square root
    logic        w_sq_start, w_sq_done;
    logic [31:0] w_root;
    rvr_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_val(r_var << 8), .o_done(w_sq_done), .o_root(w_root)
    );

    // return inputs
    logic [31:0] w_dmag;
    logic        w_dneg;
    assign w_dneg = r_in.tick_price < r_last_price;
    assign w_dmag = w_dneg ? r_last_price - r_in.tick_price : r_in.tick_price - r_last_price;

    // interval
    logic [63:0] w_ivraw;
    logic [47:0] w_iv;
    always_comb begin
        w_ivraw = r_in.time_ns - r_last_time;
        if (w_ivraw == 64'd0)                 w_iv = ZeroInterval;
        else if (w_ivraw[63:48] != 16'd0)     w_iv = IntervalMax;
        else                                  w_iv = w_ivraw[47:0];
    end

    // old ring entry
    logic signed [31:0] w_old_r;
    logic [47:0]        w_old_i;
    logic [31:0]        w_old_m, w_new_m;
    logic [63:0]        w_old_sq, w_new_sq;
    assign w_old_r  = w_rdata[79:48];
    assign w_old_i  = w_rdata[47:0];
    assign w_old_m  = w_old_r[31] ? 32'(-w_old_r) : w_old_r;
    assign w_new_m  = r_ret[32] ? 32'(-r_ret) : r_ret[31:0];
    assign w_old_sq = ({32'd0, w_old_m} * {32'd0, w_old_m}) >> 8;
    assign w_new_sq = ({32'd0, w_new_m} * {32'd0, w_new_m}) >> 8;

    logic w_full;
    assign w_full = (r_fill == CntW'(Window));
    logic [37:0] w_rsum_mag;
    assign w_rsum_mag = r_rsum[37] ? 38'(-r_rsum) : r_rsum;

    logic [127:0] w_q;
    assign w_q = w_rsp.quo;

    logic [63:0] w_msq;
    assign w_msq = (r_mm[31:0] * r_mm[31:0]) >> 8;

    // one quotient chunk: remainder so far and the next 16 dividend bits
    assign w_c_v    = {r_c_rem, r_c_x[63:48]};
    assign w_c_prod = 47'(w_c_v) * 47'(Div100Recip);
    assign w_c_qd   = w_c_prod[45:30];
    assign w_c_rem  = w_c_v - 23'(w_c_qd) * 23'd100;
    assign w_c_q    = {r_c_q[47:0], w_c_qd};

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state;
        n_wait = r_wait;
        w_req = '0;
        w_sq_start = 1'b0;
        w_we = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_RET;
            S_RET: begin
                // priming sample goes straight to output, else run the return division
                if (r_last_price == 32'd0) n_state = S_OUT;
                else if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = {66'd0, w_dmag, 30'd0} + {96'd0, 1'b0, r_last_price[31:1]};
                    w_req.den = {32'd0, r_last_price};
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_state = S_RD;
                end
            end
            S_RD: n_state = S_ACC;  // ring read of old slot in flight
            S_ACC: begin
                w_we = 1'b1;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = {90'd0, w_rsum_mag} + 128'(r_fill >> 1);
                    w_req.den = 64'(r_fill);
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_state = S_MSQ;
                end
            end
            S_MSQ: begin
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = {64'd0, r_ssum};
                    w_req.den = 64'(r_fill);
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_state = S_VAR;
                end
            end
            S_VAR: begin
                w_sq_start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: if (w_sq_done) n_state = S_RATE;
            S_RATE: begin
                if (!r_wait) begin
                    w_req.start = 1'b1;
                    w_req.num = 128'(RateScale * 64'(r_fill)) + 128'(r_isum >> 1);
                    w_req.den = {10'd0, r_isum};
                    n_wait = 1'b1;
                end else if (w_rsp.done) begin
                    n_wait = 1'b0; n_state = S_EMAV;
                end
            end
            S_EMAV: begin
                // seed an empty baseline, else load and run four chunks
                if (r_vbase == 32'd0) n_state = S_EMAR;
                else if (!r_wait) n_wait = 1'b1;
                else if (r_c_cnt == 2'd3) begin
                    n_wait = 1'b0; n_state = S_EMAR;
                end
            end
            S_EMAR: begin
                if (r_rbase == 48'd0) n_state = S_OUT;
                else if (!r_wait) n_wait = 1'b1;
                else if (r_c_cnt == 2'd3) begin
                    n_wait = 1'b0; n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_wait <= 1'b0; r_ovalid <= 1'b0;
            r_last_price <= '0; r_last_time <= '0; r_fill <= '0; r_slot <= '0;
            r_rsum <= '0; r_ssum <= '0; r_isum <= '0;
            r_vol <= '0; r_rate <= '0; r_vbase <= '0; r_rbase <= '0;
            r_sub <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) r_in <= i_data;
                S_RET: begin
                    r_iv <= w_iv;
                    r_sub <= w_full;
                    if (r_wait && w_rsp.done) begin
                        // saturate to Q2.30 limits with sign of the difference
                        if (w_dneg)
                            r_ret <= (w_q > 128'd2147483648) ? -33'sd2147483648
                                                              : -$signed({1'b0, w_q[31:0]});
                        else
                            r_ret <= (w_q > 128'd2147483647) ? 33'sd2147483647
                                                              : $signed({1'b0, w_q[31:0]});
                    end
                end
                S_ACC: begin
                    // retire the oldest entry when full, then add the new one
                    if (r_sub) begin
                        r_rsum <= r_rsum - 38'(w_old_r) + 38'(r_ret);
                        r_ssum <= r_ssum - w_old_sq + w_new_sq;
                        r_isum <= r_isum - 54'(w_old_i) + 54'(r_iv);
                    end else begin
                        r_rsum <= r_rsum + 38'(r_ret);
                        r_ssum <= r_ssum + w_new_sq;
                        r_isum <= r_isum + 54'(r_iv);
                        r_fill <= r_fill + CntW'(1);
                    end
                    r_slot <= (r_slot == SlotW'(Window - 1)) ? '0 : r_slot + SlotW'(1);
                end
                S_MEAN: if (r_wait && w_rsp.done) r_mm <= w_q[63:0];
                S_MSQ: if (r_wait && w_rsp.done)
                    r_var <= (w_q[63:0] > w_msq) ? w_q[63:0] - w_msq : 64'd0;
                S_SQRT: if (w_sq_done) r_vol <= w_root;
                S_RATE: if (r_wait && w_rsp.done) begin
                    r_rate <= w_q[47:0];
                    r_mm   <= 64'(r_vbase) * 64'd99 + 64'(r_vol) + 64'd50;
                end
                S_EMAV: begin
                    if (r_vbase == 32'd0) begin
                        r_vbase <= r_vol;
                    end else if (!r_wait) begin
                        r_c_x <= r_mm; r_c_rem <= '0; r_c_cnt <= '0;
                    end else begin
                        r_c_x <= {r_c_x[47:0], 16'd0};
                        r_c_rem <= w_c_rem[6:0];
                        r_c_q <= w_c_q;
                        r_c_cnt <= r_c_cnt + 2'd1;
                        if (r_c_cnt == 2'd3) r_vbase <= w_c_q[31:0];
                    end
                    r_var <= 64'(r_rbase) * 64'd99 + 64'(r_rate) + 64'd50;
                end
                S_EMAR: begin
                    if (r_rbase == 48'd0) begin
                        r_rbase <= r_rate;
                    end else if (!r_wait) begin
                        r_c_x <= r_var; r_c_rem <= '0; r_c_cnt <= '0;
                    end else begin
                        r_c_x <= {r_c_x[47:0], 16'd0};
                        r_c_rem <= w_c_rem[6:0];
                        r_c_q <= w_c_q;
                        r_c_cnt <= r_c_cnt + 2'd1;
                        if (r_c_cnt == 2'd3) r_rbase <= w_c_q[47:0];
                    end
                end
                S_OUT: begin
                    r_last_price <= r_in.tick_price;
                    r_last_time  <= r_in.time_ns;
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            r_out.primed <= (r_last_price != 32'd0);
            r_out.regime <= {r_vol > r_vbase, r_rate > r_rbase};
            r_out.volatility <= r_vol;
            r_out.intensity <= r_rate;
            r_out.volatility_baseline <= r_vbase;
            r_out.intensity_baseline <= r_rbase;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // window count never exceeds the ring depth; a held result blocks intake
    `RVR_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= CntW'(Window))
    `RVR_ASSERT_IMP(a_no_intake_when_held, i_clk, i_rst_n, o_valid, !o_ready)
    `RVR_ASSERT_NEXT(a_out_after_accept, i_clk, i_rst_n, r_state == S_OUT, o_valid)
endmodule
`default_nettype wire
